// File: hdl/utf8tc_pkg.sv
// Shared types and constants of the internal-text / UTF-8 transcoder.
// Used by the front classifier, the job queue, the byte sequencer and the top level.
package utf8tc_pkg;

   localparam int QueueDepth = 2;

   localparam logic [7:0] TopBitMask  = 8'h80;
   localparam logic [7:0] Lead2Mark   = 8'hC0;
   localparam logic [7:0] Lead3Mark   = 8'hE0;
   localparam logic [7:0] Lead2Mask   = 8'hE0;
   localparam logic [7:0] ContMark    = 8'h80;
   localparam logic [15:0] WideMark   = 16'h8000;
   localparam logic [15:0] OneByteMax = 16'h007F;
   localparam logic [15:0] TwoByteMax = 16'h07FF;

   localparam logic DirEncode = 1'b0;
   localparam logic DirDecode = 1'b1;

   typedef logic [7:0] octet_type;

   // One queued job: the result bytes caused by one input beat, first byte in data[0].
   typedef struct packed {
      logic [1:0]          count;
      octet_type [2:0]     data;
   } job_type;

endpackage

// File: hdl/internal_text_utf8_transcoder.sv
// Transcoder between the two-byte internal text encoding and UTF-8, with the
// direction set by a one-bit register (0 encode to UTF-8, 1 decode from UTF-8).
// An input beat is taken every cycle while the job queue has room; each beat
// becomes zero to three result bytes, and the result port sends one byte per
// cycle while rsp_stall is low. With the result side idle, the first result byte
// is written to a queue entry and then loaded into the sequencer's job register
// before it is offered. Writing the register also drops any unfinished
// character.
module internal_text_utf8_transcoder #(
   parameter int QueueDepth = utf8tc_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   logic                push;
   logic                pop;
   logic                queue_full;
   logic                queue_empty;
   utf8tc_pkg::job_type push_job;
   utf8tc_pkg::job_type head_job;

   utf8tc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   utf8tc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   utf8tc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// File: hdl/utf8tc_front.sv
// Front of the transcoder: takes input beats, tracks the partial character and
// turns each beat into a job of zero to three result bytes. Uses utf8tc_pkg.
module utf8tc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_in_byte,
   input  logic                     queue_full,
   output logic                     push,
   output utf8tc_pkg::job_type      push_job
);

   logic        direction_ff, direction_in;
   logic [1:0]  pending_ff, pending_in;
   logic [15:0] accum_ff, accum_in;
   logic        accept;
   logic [14:0] enc_cp;
   logic [15:0] dec_cp;
   utf8tc_pkg::job_type job;

   // A decoded code point leaves as one byte, or as two bytes with the top bit set.
   function automatic utf8tc_pkg::job_type emit_cp(input logic [15:0] cp);
      utf8tc_pkg::job_type j;
      logic [15:0] wide;
      wide = cp | utf8tc_pkg::WideMark;
      j = '0;
      if (cp <= utf8tc_pkg::OneByteMax) begin
         j.count   = 2'd1;
         j.data[0] = cp[7:0];
      end else begin
         j.count   = 2'd2;
         j.data[0] = wide[15:8];
         j.data[1] = wide[7:0];
      end
      return j;
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign enc_cp    = {accum_ff[14:8], req_in_byte};
   assign dec_cp    = accum_ff | {10'd0, req_in_byte[5:0]};

   always_comb begin
      direction_in = direction_ff;
      pending_in   = pending_ff;
      accum_in     = accum_ff;
      job          = '0;
      if (csr_wr_en) begin
         direction_in = csr_wr_data;
         pending_in   = 2'd0;
         accum_in     = '0;
      end else if (accept) begin
         if (direction_ff == utf8tc_pkg::DirEncode) begin
            if (pending_ff == 2'd0) begin
               if ((req_in_byte & utf8tc_pkg::TopBitMask) == 8'd0) begin
                  job.count   = 2'd1;
                  job.data[0] = req_in_byte;
               end else begin
                  accum_in   = {1'b0, req_in_byte[6:0], 8'd0};
                  pending_in = 2'd1;
               end
            end else begin
               pending_in = 2'd0;
               accum_in   = '0;
               if (enc_cp == 15'd0) begin
                  job.count = 2'd0;
               end else if ({1'b0, enc_cp} <= utf8tc_pkg::OneByteMax) begin
                  job.count   = 2'd1;
                  job.data[0] = enc_cp[7:0];
               end else if ({1'b0, enc_cp} <= utf8tc_pkg::TwoByteMax) begin
                  job.count   = 2'd2;
                  job.data[0] = utf8tc_pkg::Lead2Mark | {3'd0, enc_cp[10:6]};
                  job.data[1] = utf8tc_pkg::ContMark | {2'd0, enc_cp[5:0]};
               end else begin
                  job.count   = 2'd3;
                  job.data[0] = utf8tc_pkg::Lead3Mark | {5'd0, enc_cp[14:12]};
                  job.data[1] = utf8tc_pkg::ContMark | {2'd0, enc_cp[11:6]};
                  job.data[2] = utf8tc_pkg::ContMark | {2'd0, enc_cp[5:0]};
               end
            end
         end else begin
            case (pending_ff)
               2'd0: begin
                  if ((req_in_byte & utf8tc_pkg::TopBitMask) == 8'd0) begin
                     // A zero lead byte also lands here and is passed on as the byte 0x00.
                     accum_in = '0;
                     job      = emit_cp({8'd0, req_in_byte});
                  end else if ((req_in_byte & utf8tc_pkg::Lead2Mask)
                               == utf8tc_pkg::Lead2Mark) begin
                     accum_in   = {5'd0, req_in_byte[4:0], 6'd0};
                     pending_in = 2'd1;
                  end else begin
                     accum_in   = {req_in_byte[3:0], 12'd0};
                     pending_in = 2'd2;
                  end
               end
               2'd1: begin
                  pending_in = 2'd0;
                  accum_in   = '0;
                  job        = emit_cp(dec_cp);
               end
               default: begin
                  accum_in   = accum_ff | {4'd0, req_in_byte[5:0], 6'd0};
                  pending_in = 2'd1;
               end
            endcase
         end
      end
   end

   assign push     = accept && (job.count != 2'd0);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= utf8tc_pkg::DirEncode;
         pending_ff   <= 2'd0;
         accum_ff     <= '0;
      end else begin
         direction_ff <= direction_in;
         pending_ff   <= pending_in;
         accum_ff     <= accum_in;
      end
   end

endmodule

// File: hdl/utf8tc_queue.sv
// Short job queue between the front classifier and the byte sequencer.
// Holds utf8tc_pkg::job_type entries in arrival order.
module utf8tc_queue #(
   parameter int Depth = utf8tc_pkg::QueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  utf8tc_pkg::job_type      push_job,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output utf8tc_pkg::job_type      head_job
);

   localparam int PtrWidth  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int FillWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]  LastSlot = PtrWidth'(Depth - 1);
   localparam logic [FillWidth-1:0] FullFill = FillWidth'(Depth);

   utf8tc_pkg::job_type entry_ff [Depth];
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FillWidth-1:0] fill_ff, fill_in;

   assign full     = (fill_ff == FullFill);
   assign empty    = (fill_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FillWidth'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FillWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// File: hdl/utf8tc_back.sv
// Back of the transcoder: takes jobs from the queue and sends their bytes one
// beat at a time, marking the final byte of each job. Uses utf8tc_pkg.
module utf8tc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     queue_empty,
   input  utf8tc_pkg::job_type      head_job,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last_of_run
);

   utf8tc_pkg::job_type job_ff, job_in;
   logic        busy_ff, busy_in;
   logic [1:0]  idx_ff, idx_in;
   logic        sent;
   logic        last;

   assign last            = (idx_ff == 2'(job_ff.count - 2'd1));
   assign sent            = busy_ff && !rsp_stall;
   assign pop             = !queue_empty && (!busy_ff || (sent && last));
   assign rsp_valid       = busy_ff;
   assign rsp_out_byte    = job_ff.data[idx_ff];
   assign rsp_last_of_run = last;

   always_comb begin
      job_in  = job_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         // The next job loads in the same cycle the final byte leaves.
         job_in  = head_job;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (sent) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

endmodule
